>>> rtl/sts_pkg.sv
package sts_pkg;

   localparam int SCHED_DEPTH_DEFAULT = 16;
   localparam int SLOT_W = 48;
   localparam int ADDR_W = 16;
   localparam int OCC_W = 5;

   typedef enum logic [2:0] {
      OP_ORIGINATE = 3'd0,
      OP_RELAY     = 3'd1,
      OP_TAKE      = 3'd2,
      OP_SUPPRESS  = 3'd3,
      OP_FLUSH     = 3'd4
   } opcode_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ROOM = 2'd1;
   localparam logic [1:0] ST_EXPIRED = 2'd2;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {S_IDLE, S_HIT, S_FREE, S_APPLY, S_COUNT, S_DONE} st_type;

   // Operation broadcast to every cell during the apply phase.
   typedef struct packed {
      logic        take;
      logic        suppress;
      logic        flush;
      logic [47:0] slot;
      logic [15:0] origin;
      logic [7:0]  sequence_num;
   } cmd_type;

   // Frame record held by a cell.
   typedef struct packed {
      logic [47:0] slot;
      logic [2:0]  priority_val;
      logic [15:0] origin;
      logic [7:0]  sequence_num;
      logic [7:0]  hop_limit;
      logic [15:0] prev_hop;
      logic [7:0]  payload;
   } frame_type;

   // Search token that ripples down the chain, one cell per cycle.
   typedef struct packed {
      logic        active;
      logic        hit;
      logic        free_seen;
      logic        found;
      logic [OCC_W-1:0] count;
   } token_type;

endpackage

>>> rtl/sts_cell.sv
module sts_cell (
   input  logic               clock,
   input  logic               reset,
   input  sts_pkg::cmd_type   cmd,
   input  logic               cmd_valid,
   input  logic               scan_first,
   input  sts_pkg::frame_type book_frame,
   input  logic               book_en,
   input  logic               book_free_en,
   input  sts_pkg::token_type tok_i,
   output sts_pkg::token_type tok_o,
   output sts_pkg::frame_type frame_o,
   output logic               take_hit_o,
   output logic               sup_hit_o
);
   import sts_pkg::*;

   logic      valid_ff, valid_in;
   frame_type frame_ff, frame_in;
   token_type tok_ff, tok_in;
   logic      matched, is_free;

   assign matched = valid_ff && (frame_ff.slot == book_frame.slot);
   assign is_free = !valid_ff;
   assign take_hit_o = valid_ff && cmd.take && (frame_ff.slot == cmd.slot);
   assign sup_hit_o = valid_ff && cmd.suppress && (frame_ff.origin == cmd.origin) &&
                      (frame_ff.sequence_num == cmd.sequence_num);
   assign frame_o = frame_ff;
   assign tok_o = tok_ff;

   // Booking search, command apply and occupancy count; the token carries hit, first-free and count state.
   always_comb begin
      tok_in = tok_i;
      frame_in = frame_ff;
      valid_in = valid_ff;
      if (tok_i.active) begin
         if (book_en && !tok_i.hit && matched) begin
            tok_in.hit = 1'b1;
            tok_in.found = (book_frame.priority_val < frame_ff.priority_val);
            if (book_frame.priority_val < frame_ff.priority_val) frame_in = book_frame;
         end
         if (book_free_en && !tok_i.free_seen && is_free) begin
            tok_in.free_seen = 1'b1;
            valid_in = 1'b1;
            frame_in = book_frame;
         end
         if (book_en && !tok_i.hit && !matched && is_free && !tok_i.free_seen)
            tok_in.free_seen = 1'b1;
      end
      if (cmd_valid) begin
         if (cmd.flush) valid_in = 1'b0;
         if (cmd.take && valid_ff && frame_ff.slot <= cmd.slot) valid_in = 1'b0;
         if (sup_hit_o) valid_in = 1'b0;
      end
      // The occupancy count saturates at the top of its range.
      if (scan_first || tok_i.active)
         tok_in.count = (tok_i.count == '1) ? tok_i.count : tok_i.count + OCC_W'(valid_in);
      tok_in.active = tok_i.active | scan_first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff <= tok_in;
      end
      frame_ff <= frame_in;
   end
endmodule

>>> rtl/slot_transmit_scheduler_unit.sv
// Slot transmit scheduler. The frame table is a chain of SCHED_DEPTH cells;
// a search token walks the chain one cell per cycle. A booking (originate or
// relay with a nonzero hop limit) runs a hit search, a free-entry search and
// an occupancy count, then a finish step; take, suppress, flush, unknown
// operations and relays with a zero hop limit run an apply step, the count
// and the finish step. A new request can be accepted the cycle after the finish.
// One transaction is in work at a time; the result sits in an output register
// so the next request may be accepted while the response waits, and a later
// result waits in the finish state until that register is free.
module slot_transmit_scheduler_unit #(
   parameter int SCHED_DEPTH = sts_pkg::SCHED_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[2:0], target_slot[50:3], priority_req[53:51], origin_addr[69:54],
   // sequence_req[77:70], hop_limit[85:78], prev_hop[101:86],
   // payload_tag[109:102], zero fill to 111
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], found[2], out_priority[5:3], out_origin[21:6],
   // out_sequence[29:22], out_hop_limit[37:30], out_prev_hop[53:38],
   // out_payload_tag[61:54], occupancy[66:62], zero fill to 71
   output logic [71:0]  rsp_tdata
);
   import sts_pkg::*;

   localparam int CW = $clog2(2*SCHED_DEPTH+4);

   st_type      state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0] node_ff;
   logic [2:0]  op_ff;
   frame_type   bf_ff;
   logic        bad_hop_ff;
   logic        hit_ff, hitgood_ff, free_ff, found_ff;
   frame_type   take_frame_ff;
   logic        rsp_v_ff;
   logic [71:0] rsp_d_ff;
   logic [47:0] last_slot_ff;
   logic        any_taken_ff;
   logic [OCC_W-1:0] occ_ff;

   cmd_type   cmd;
   logic      cmd_valid, scan_first, book_en, book_free_en;
   token_type tok [0:SCHED_DEPTH];
   frame_type frames [SCHED_DEPTH];
   logic [SCHED_DEPTH-1:0] take_hits;
   logic [SCHED_DEPTH-1:0] sup_hits;
   frame_type take_sel;
   logic      any_hit;
   logic [OCC_W-1:0] occ;
   logic      done_go;
   logic [1:0] status_val;

   assign cmd.take = (op_ff == OP_TAKE);
   assign cmd.suppress = (op_ff == OP_SUPPRESS);
   assign cmd.flush = (op_ff == OP_FLUSH);
   assign cmd.slot = bf_ff.slot;
   assign cmd.origin = bf_ff.origin;
   assign cmd.sequence_num = bf_ff.sequence_num;
   assign cmd_valid = (state_ff == S_APPLY);
   assign scan_first = (state_ff == S_COUNT) && (cnt_ff == '0);
   assign book_en = (state_ff == S_HIT);
   assign book_free_en = (state_ff == S_FREE);

   always_comb begin
      tok[0] = '0;
      tok[0].active = ((state_ff == S_HIT) || (state_ff == S_FREE)) && (cnt_ff == '0);
   end

   genvar g;
   generate
      for (g = 0; g < SCHED_DEPTH; g++) begin : g_cell
         token_type ti;
         always_comb begin
            ti = tok[g];
            if (g != 0 && state_ff == S_COUNT) ti.active = 1'b0;
            if (g == 0 && state_ff == S_COUNT) ti = '0;
            if (g != 0 && (state_ff == S_COUNT)) ti = tok[g];
         end
         sts_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .cmd_valid(cmd_valid),
            .scan_first(scan_first && g == 0), .book_frame(bf_ff),
            .book_en(book_en), .book_free_en(book_free_en && !hit_ff),
            .tok_i(ti), .tok_o(tok[g+1]), .frame_o(frames[g]),
            .take_hit_o(take_hits[g]), .sup_hit_o(sup_hits[g])
         );
      end
   endgenerate

   // Slot numbers are unique among valid entries, so an OR of hits selects the frame.
   always_comb begin
      take_sel = '0;
      for (int i = 0; i < SCHED_DEPTH; i++)
         if (take_hits[i]) take_sel = take_sel | frames[i];
   end
   assign any_hit = |take_hits;
   assign occ = tok[SCHED_DEPTH].count;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_d_ff;
   assign done_go = (state_ff == S_DONE) && (!rsp_v_ff || rsp_tready);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            cnt_in = '0;
            if ((req_tdata[2:0] == OP_ORIGINATE) ||
                (req_tdata[2:0] == OP_RELAY && req_tdata[85:78] != 8'd0))
               state_in = S_HIT;
            else state_in = S_APPLY;
         end
         S_HIT, S_FREE, S_COUNT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SCHED_DEPTH)) begin
               cnt_in = '0;
               state_in = (state_ff == S_HIT) ? S_FREE :
                          (state_ff == S_FREE) ? S_COUNT : S_DONE;
            end
         end
         S_APPLY: begin
            cnt_in = '0;
            state_in = S_COUNT;
         end
         S_DONE: if (done_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         node_ff <= '0;
         rsp_v_ff <= 1'b0;
         last_slot_ff <= '0;
         any_taken_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         if (csr_we) node_ff <= csr_wdata;
         if (done_go) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
         if (cmd_valid && cmd.take && any_hit) begin
            last_slot_ff <= cmd.slot;
            any_taken_ff <= 1'b1;
         end
      end
   end

   // Response status from the search results.
   always_comb begin
      if (bad_hop_ff) status_val = ST_EXPIRED;
      else if ((op_ff == OP_ORIGINATE || op_ff == OP_RELAY) &&
               (hit_ff ? !hitgood_ff : !free_ff)) status_val = ST_NO_ROOM;
      else status_val = ST_OK;
   end

   // Request capture, search results and response assembly.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid && req_tready) begin
         op_ff <= req_tdata[2:0];
         bad_hop_ff <= (req_tdata[2:0] == OP_RELAY) && (req_tdata[85:78] == 8'd0);
         bf_ff.priority_val <= req_tdata[53:51];
         bf_ff.origin <= req_tdata[69:54];
         bf_ff.sequence_num <= req_tdata[77:70];
         bf_ff.payload <= req_tdata[109:102];
         if (req_tdata[2:0] == OP_RELAY) begin
            bf_ff.slot <= req_tdata[50:3] + 48'd1;
            bf_ff.hop_limit <= req_tdata[85:78] - 8'd1;
            bf_ff.prev_hop <= node_ff;
         end else begin
            bf_ff.slot <= req_tdata[50:3];
            bf_ff.hop_limit <= req_tdata[85:78];
            bf_ff.prev_hop <= req_tdata[101:86];
         end
         hit_ff <= 1'b0;
         hitgood_ff <= 1'b0;
         free_ff <= 1'b0;
         found_ff <= 1'b0;
         take_frame_ff <= '0;
      end
      if (state_ff == S_HIT && cnt_ff == CW'(SCHED_DEPTH)) begin
         hit_ff <= tok[SCHED_DEPTH].hit;
         hitgood_ff <= tok[SCHED_DEPTH].found;
      end
      if (state_ff == S_FREE && cnt_ff == CW'(SCHED_DEPTH))
         free_ff <= tok[SCHED_DEPTH].free_seen;
      if (cmd_valid) begin
         if (cmd.take) begin
            found_ff <= any_hit;
            if (any_hit) take_frame_ff <= take_sel;
         end
         if (cmd.suppress) found_ff <= |sup_hits;
      end
      if (done_go)
         rsp_d_ff <= {5'd0, occ_ff, take_frame_ff.payload, take_frame_ff.prev_hop,
                      take_frame_ff.hop_limit, take_frame_ff.sequence_num,
                      take_frame_ff.origin, take_frame_ff.priority_val, found_ff,
                      status_val};
   end

   always_ff @(posedge clock)
      if (state_ff == S_COUNT && cnt_ff == CW'(SCHED_DEPTH)) occ_ff <= occ;

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_DONE) else $error("stray response");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
`endif
endmodule

>>> dv/slot_transmit_scheduler_checker.sv
module slot_transmit_scheduler_checker #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   output int           fail_count,
   output int           pending_count,
   output int           frames_taken
);
   timeunit 1ns;
   timeprecision 1ps;
   import sts_pkg::*;

   // Fields from the highest bit down, matching the response packing.
   typedef struct packed {
      logic [4:0]  occ;
      logic [7:0]  tag;
      logic [15:0] prev;
      logic [7:0]  hops;
      logic [7:0]  seq;
      logic [15:0] origin;
      logic [2:0]  pri;
      logic        found;
      logic [1:0]  status;
   } outcome_t;

   // Shadow copy of the frame table.
   logic        tbl_valid [DEPTH];
   logic [47:0] tbl_slot [DEPTH];
   logic [2:0]  tbl_pri [DEPTH];
   logic [15:0] tbl_origin [DEPTH];
   logic [7:0]  tbl_seq [DEPTH];
   logic [7:0]  tbl_hops [DEPTH];
   logic [15:0] tbl_prev [DEPTH];
   logic [7:0]  tbl_tag [DEPTH];
   logic [15:0] own_address;
   outcome_t    expected_outcomes[$];

   assign pending_count = expected_outcomes.size();

   // Book a frame; returns the status code.
   function automatic logic [1:0] book_frame(logic [47:0] slot, logic [2:0] pri,
         logic [15:0] org, logic [7:0] seq, logic [7:0] hops, logic [15:0] prev,
         logic [7:0] tag);
      int target;
      target = -1;
      for (int k = 0; k < DEPTH; k++)
         if (target < 0 && tbl_valid[k] && tbl_slot[k] == slot) target = k;
      if (target >= 0) begin
         if (!(pri < tbl_pri[target])) return ST_NO_ROOM;
      end else begin
         for (int k = 0; k < DEPTH; k++)
            if (target < 0 && !tbl_valid[k]) target = k;
         if (target < 0) return ST_NO_ROOM;
      end
      tbl_valid[target] = 1'b1;
      tbl_slot[target] = slot;
      tbl_pri[target] = pri;
      tbl_origin[target] = org;
      tbl_seq[target] = seq;
      tbl_hops[target] = hops;
      tbl_prev[target] = prev;
      tbl_tag[target] = tag;
      return ST_OK;
   endfunction

   // Apply one request to the shadow table and return its outcome.
   function automatic outcome_t schedule_outcome(logic [111:0] d);
      outcome_t o;
      logic [2:0]  op;
      logic [47:0] slot;
      int n;
      o = '0;
      op = d[2:0];
      slot = d[50:3];
      case (op)
         OP_ORIGINATE: o.status = book_frame(slot, d[53:51], d[69:54], d[77:70],
               d[85:78], d[101:86], d[109:102]);
         OP_RELAY: begin
            if (d[85:78] == 8'd0) o.status = ST_EXPIRED;
            else o.status = book_frame(slot + 48'd1, d[53:51], d[69:54],
                  d[77:70], d[85:78] - 8'd1, own_address, d[109:102]);
         end
         OP_TAKE: begin
            for (int k = 0; k < DEPTH; k++) begin
               if (!tbl_valid[k]) continue;
               if (tbl_slot[k] == slot) begin
                  o.pri = tbl_pri[k];
                  o.origin = tbl_origin[k];
                  o.seq = tbl_seq[k];
                  o.hops = tbl_hops[k];
                  o.prev = tbl_prev[k];
                  o.tag = tbl_tag[k];
                  o.found = 1'b1;
                  tbl_valid[k] = 1'b0;
               end else if (tbl_slot[k] < slot) begin
                  tbl_valid[k] = 1'b0;
               end
            end
         end
         OP_SUPPRESS: begin
            for (int k = 0; k < DEPTH; k++)
               if (tbl_valid[k] && tbl_origin[k] == d[69:54] && tbl_seq[k] == d[77:70]) begin
                  tbl_valid[k] = 1'b0;
                  o.found = 1'b1;
               end
         end
         OP_FLUSH: for (int k = 0; k < DEPTH; k++) tbl_valid[k] = 1'b0;
         default: ;
      endcase
      n = 0;
      for (int k = 0; k < DEPTH; k++) n += tbl_valid[k];
      o.occ = (n > 31) ? 5'd31 : n[4:0];
      return o;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Predict on each accepted request, compare on each accepted response.
   always @(posedge clock) begin
      outcome_t want, got;
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) tbl_valid[k] = 1'b0;
         own_address = '0;
         expected_outcomes.delete();
         fail_count = 0;
         frames_taken = 0;
      end else begin
         if (csr_we) own_address = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[66:0];
            if (expected_outcomes.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = expected_outcomes.pop_front();
               compare_field("status", 64'(want.status), 64'(got.status));
               compare_field("found", 64'(want.found), 64'(got.found));
               compare_field("out_priority", 64'(want.pri), 64'(got.pri));
               compare_field("out_origin", 64'(want.origin), 64'(got.origin));
               compare_field("out_sequence", 64'(want.seq), 64'(got.seq));
               compare_field("out_hop_limit", 64'(want.hops), 64'(got.hops));
               compare_field("out_prev_hop", 64'(want.prev), 64'(got.prev));
               compare_field("out_payload_tag", 64'(want.tag), 64'(got.tag));
               compare_field("occupancy", 64'(want.occ), 64'(got.occ));
               if (want.found && want.status == ST_OK) frames_taken++;
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(schedule_outcome(req_tdata));
      end
   end

endmodule

>>> dv/slot_transmit_scheduler_unit_tb.sv
module slot_transmit_scheduler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sts_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_ITEMS = 750;
   localparam int IDLE_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [15:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;
   int           fail_count, pending_count, frames_taken;
   int           idle_cycles = 0;
   int           sent_count = 0;
   logic         stall_mode = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   slot_transmit_scheduler_unit #(.SCHED_DEPTH(DEPTH)) DUT (
      .clock, .reset, .csr_we, .csr_wdata, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   slot_transmit_scheduler_checker #(.DEPTH(DEPTH)) checker_inst (
      .clock, .reset, .csr_we, .csr_wdata, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .pending_count, .frames_taken
   );

   // Receiver stalls: phases of free flow alternate with phases of random stalls.
   always @(posedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Drive one request transaction and hold it until accepted.
   task automatic send_request(opcode_type op, logic [47:0] slot, logic [2:0] pri,
         logic [15:0] org, logic [7:0] seq, logic [7:0] hops, logic [15:0] prev,
         logic [7:0] tag);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, tag, prev, hops, seq, org, pri, slot, op};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic send_raw(logic [2:0] op);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, 107'({$urandom(), $urandom(), $urandom(), $urandom()}), op};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Idle phase before a register write; bookings are slow so allow a margin.
   task automatic write_address(logic [15:0] value);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Slots mostly come from a small window so that collisions, takes and stale drops happen.
   function automatic logic [47:0] pick_slot(logic [47:0] base);
      case ($urandom_range(0, 9))
         0: return {$urandom(), 16'($urandom())};
         1: return 48'hFFFF_FFFF_FFFF - $urandom_range(0, 2);
         default: return base + $urandom_range(0, 24);
      endcase
   endfunction

   initial begin
      logic [47:0] base;
      int burst;
      opcode_type op;
      logic [15:0] org;
      logic [7:0] seq;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_address(16'hA5C3);

      // Directed: extremes, every operation, priority replacement, a zero hop limit and a full table.
      send_request(OP_ORIGINATE, 48'd0, 3'd7, 16'h0000, 8'h00, 8'h00, 16'h0000, 8'h00);
      send_request(OP_ORIGINATE, 48'd0, 3'd7, 16'h1111, 8'h01, 8'h01, 16'h0001, 8'h01);
      send_request(OP_ORIGINATE, 48'd0, 3'd3, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      send_request(OP_RELAY, 48'hFFFF_FFFF_FFFF, 3'd0, 16'h1234, 8'h56, 8'hFF, 16'h9999, 8'h77);
      send_request(OP_RELAY, 48'd5, 3'd1, 16'h1234, 8'h56, 8'h00, 16'h9999, 8'h78);
      send_request(OP_RELAY, 48'd9, 3'd2, 16'h4321, 8'h10, 8'h01, 16'h0000, 8'h79);
      send_request(OP_TAKE, 48'd0, 3'd0, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0);
      send_request(OP_TAKE, 48'd3, 3'd0, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0);
      drop_valid();
      for (int i = 0; i < DEPTH + 2; i++)
         send_request(OP_ORIGINATE, 48'd100 + i, 3'(i), 16'hBEEF, 8'(i % 2), 8'(i),
               16'(i), 8'(i));
      send_request(OP_SUPPRESS, 48'd0, 3'd0, 16'hBEEF, 8'h01, 8'h0, 16'h0, 8'h0);
      send_request(OP_SUPPRESS, 48'd0, 3'd0, 16'hBEEF, 8'h07, 8'h0, 16'h0, 8'h0);
      send_request(OP_TAKE, 48'd110, 3'd0, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0);
      send_raw(3'd5);
      send_raw(3'd6);
      send_raw(3'd7);
      send_request(OP_FLUSH, 48'd0, 3'd0, 16'h0, 8'h0, 8'h0, 16'h0, 8'h0);

      // Random phases under several node addresses, extremes among them.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_address(16'h0000);
            1: write_address(16'hFFFF);
            default: write_address(16'($urandom()));
         endcase
         base = {$urandom(), 16'($urandom())};
         while (sent_count < (phase + 1) * RANDOM_ITEMS / 4) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6: op = OP_ORIGINATE;
                  7, 8, 9, 10: op = OP_RELAY;
                  11, 12, 13, 14, 15: op = OP_TAKE;
                  16, 17: op = OP_SUPPRESS;
                  18: op = OP_FLUSH;
                  default: op = opcode_type'($urandom_range(5, 7));
               endcase
               org = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
               seq = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
               send_request(op, pick_slot(base), 3'($urandom()), org, seq,
                     ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom()),
                     16'($urandom()), 8'($urandom()));
               if (op == OP_TAKE && $urandom_range(0, 3) == 0) base += $urandom_range(1, 6);
            end
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(posedge clock);
         end
      end

      // Drain and let the block settle.
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);
      $display("Sent %0d request transactions; %0d responses reported a frame found.",
            sent_count, frames_taken);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
